[hw/rtl/hsvp_pkg.sv]
// Shared types, constants and a helper function for the HSV-percent to RGB converter.
package hsvp_pkg;

  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;
  localparam int unsigned OffW  = 6;
  localparam int unsigned ProdW = 15;

  localparam logic [HueW-1:0]  HUE_MAX  = 9'd359;
  localparam logic [PctW-1:0]  PCT_MAX  = 7'd100;
  localparam logic [ChanW-1:0] FULL     = 8'd255;
  localparam logic [8:0]       RAMP_NUM = 9'd425;

  // Sector lower bounds (first sector starts at zero)
  localparam logic [HueW-1:0] HUE_B1 = 9'd61;
  localparam logic [HueW-1:0] HUE_B2 = 9'd121;
  localparam logic [HueW-1:0] HUE_B3 = 9'd181;
  localparam logic [HueW-1:0] HUE_B4 = 9'd241;
  localparam logic [HueW-1:0] HUE_B5 = 9'd301;

  // Ramp origins: multiples of 60 degrees
  localparam logic [HueW-1:0] HUE_O1 = 9'd60;
  localparam logic [HueW-1:0] HUE_O2 = 9'd120;
  localparam logic [HueW-1:0] HUE_O3 = 9'd180;
  localparam logic [HueW-1:0] HUE_O4 = 9'd240;
  localparam logic [HueW-1:0] HUE_O5 = 9'd300;

  // floor(x/100) == (x * 5243) >> 19 for every x below 2^15
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int unsigned RecipSh  = 19;

  typedef enum logic [2:0] {
    SEC_RY,   // red full, green rises
    SEC_YG,   // green full, red falls
    SEC_GC,   // green full, blue rises
    SEC_CB,   // blue full, green falls
    SEC_BM,   // blue full, red rises
    SEC_MR    // red full, blue falls
  } sector_t;

  typedef struct packed {
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [ProdW-1:0] r;
    logic [ProdW-1:0] g;
    logic [ProdW-1:0] b;
  } rgb_prod_t;

  function automatic logic [ChanW-1:0] div100(input logic [ProdW-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'(RECIP100);
    return p[RecipSh+ChanW-1:RecipSh];
  endfunction

endpackage

[hw/rtl/hsvp_sector.sv]
// Stages 1-2: input clamp, sector pick, hue ramp and base color.
module hsvp_sector import hsvp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [HueW-1:0] hue,
  input  logic [PctW-1:0] saturation,
  input  logic [PctW-1:0] brightness,
  output logic            out_valid,
  input  logic            out_stall,
  output rgb_t            base,
  output logic [PctW-1:0] inv_sat,
  output logic [PctW-1:0] val
);

  // stage 1
  logic             s1_valid;
  sector_t          s1_sec;
  logic [ProdW-1:0] s1_prod;
  logic [PctW-1:0]  s1_inv;
  logic [PctW-1:0]  s1_val;
  // stage 2
  logic             s2_valid;
  rgb_t             s2_base;
  logic [PctW-1:0]  s2_inv;
  logic [PctW-1:0]  s2_val;

  logic             s1_stall, s2_stall;
  logic [HueW-1:0]  h_c;
  logic [PctW-1:0]  s_c, v_c;
  sector_t          sec_next;
  logic [HueW-1:0]  org;
  logic [HueW-1:0]  off_full;
  logic [OffW-1:0]  off;
  logic [ChanW-1:0] ramp;
  rgb_t             base_next;

  assign s2_stall = s2_valid & out_stall;
  assign s1_stall = s1_valid & s2_stall;
  assign in_stall = s1_stall;

  always_comb begin
    h_c = (hue > HUE_MAX) ? HUE_MAX : hue;
    s_c = (saturation > PCT_MAX) ? PCT_MAX : saturation;
    v_c = (brightness > PCT_MAX) ? PCT_MAX : brightness;
    if (h_c < HUE_B1) begin
      sec_next = SEC_RY; org = '0;
    end else if (h_c < HUE_B2) begin
      sec_next = SEC_YG; org = HUE_O1;
    end else if (h_c < HUE_B3) begin
      sec_next = SEC_GC; org = HUE_O2;
    end else if (h_c < HUE_B4) begin
      sec_next = SEC_CB; org = HUE_O3;
    end else if (h_c < HUE_B5) begin
      sec_next = SEC_BM; org = HUE_O4;
    end else begin
      sec_next = SEC_MR; org = HUE_O5;
    end
    off_full = h_c - org;
    off      = off_full[OffW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= in_valid;
    end
    if (!s1_stall && in_valid) begin
      s1_sec  <= sec_next;
      s1_prod <= ProdW'(RAMP_NUM) * ProdW'(off);
      s1_inv  <= PCT_MAX - s_c;
      s1_val  <= v_c;
    end
  end

  always_comb begin
    ramp = div100(s1_prod);
    case (s1_sec)
      SEC_RY:  base_next = '{r: FULL,        g: ramp,        b: '0};
      SEC_YG:  base_next = '{r: FULL - ramp, g: FULL,        b: '0};
      SEC_GC:  base_next = '{r: '0,          g: FULL,        b: ramp};
      SEC_CB:  base_next = '{r: '0,          g: FULL - ramp, b: FULL};
      SEC_BM:  base_next = '{r: ramp,        g: '0,          b: FULL};
      SEC_MR:  base_next = '{r: FULL,        g: '0,          b: FULL - ramp};
      default: base_next = '{r: FULL,        g: ramp,        b: '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_stall) begin
      s2_valid <= s1_valid;
    end
    if (!s2_stall && s1_valid) begin
      s2_base <= base_next;
      s2_inv  <= s1_inv;
      s2_val  <= s1_val;
    end
  end

  assign out_valid = s2_valid;
  assign base      = s2_base;
  assign inv_sat   = s2_inv;
  assign val       = s2_val;

endmodule

[hw/rtl/hsvp_lift.sv]
// Stages 3-4: saturation lift c + (255 - c) * (100 - S) / 100.
module hsvp_lift import hsvp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rgb_t            base,
  input  logic [PctW-1:0] inv_sat,
  input  logic [PctW-1:0] val,
  output logic            out_valid,
  input  logic            out_stall,
  output rgb_t            lifted,
  output logic [PctW-1:0] val_out
);

  logic            s3_valid;
  rgb_t            s3_base;
  rgb_prod_t       s3_prod;
  logic [PctW-1:0] s3_val;
  logic            s4_valid;
  rgb_t            s4_lift;
  logic [PctW-1:0] s4_val;
  logic            s3_stall, s4_stall;

  assign s4_stall = s4_valid & out_stall;
  assign s3_stall = s3_valid & s4_stall;
  assign in_stall = s3_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (!s3_stall) begin
      s3_valid <= in_valid;
    end
    if (!s3_stall && in_valid) begin
      s3_base   <= base;
      s3_prod.r <= ProdW'(ProdW'(FULL - base.r) * ProdW'(inv_sat));
      s3_prod.g <= ProdW'(ProdW'(FULL - base.g) * ProdW'(inv_sat));
      s3_prod.b <= ProdW'(ProdW'(FULL - base.b) * ProdW'(inv_sat));
      s3_val    <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (!s4_stall) begin
      s4_valid <= s3_valid;
    end
    if (!s4_stall && s3_valid) begin
      s4_lift.r <= s3_base.r + div100(s3_prod.r);
      s4_lift.g <= s3_base.g + div100(s3_prod.g);
      s4_lift.b <= s3_base.b + div100(s3_prod.b);
      s4_val    <= s3_val;
    end
  end

  assign out_valid = s4_valid;
  assign lifted    = s4_lift;
  assign val_out   = s4_val;

endmodule

[hw/rtl/hsvp_scale.sv]
// Stages 5-6: value scaling c * V / 100 into the output register.
module hsvp_scale import hsvp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rgb_t            lifted,
  input  logic [PctW-1:0] val,
  output logic            out_valid,
  input  logic            out_stall,
  output rgb_t            pix
);

  logic      s5_valid;
  rgb_prod_t s5_prod;
  logic      s6_valid;
  rgb_t      s6_pix;
  logic      s5_stall, s6_stall;

  assign s6_stall = s6_valid & out_stall;
  assign s5_stall = s5_valid & s6_stall;
  assign in_stall = s5_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (!s5_stall) begin
      s5_valid <= in_valid;
    end
    if (!s5_stall && in_valid) begin
      s5_prod.r <= ProdW'(ProdW'(lifted.r) * ProdW'(val));
      s5_prod.g <= ProdW'(ProdW'(lifted.g) * ProdW'(val));
      s5_prod.b <= ProdW'(ProdW'(lifted.b) * ProdW'(val));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (!s6_stall) begin
      s6_valid <= s5_valid;
    end
    if (!s6_stall && s5_valid) begin
      s6_pix.r <= div100(s5_prod.r);
      s6_pix.g <= div100(s5_prod.g);
      s6_pix.b <= div100(s5_prod.b);
    end
  end

  assign out_valid = s6_valid;
  assign pix       = s6_pix;

endmodule

[hw/rtl/hsv_percent_to_rgb.sv]
// Top level of the HSV-percent to RGB converter: six-stage pipeline.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  input   | in        | in_valid / in_stall  | hue[8:0] saturation[6:0] brightness[6:0]
//  output  | out       | out_valid / out_stall| red[7:0] green[7:0] blue[7:0]
//
// An input transaction is registered through stages 1 to 6 before output valid; one
// transaction per cycle is taken and delivered when the output is not stalled.
// Every stage has its own valid bit; a stage holds only while it is full and
// the stage after it holds, so bubbles are squeezed out under stall.
// in_stall is high only when all six stages are full and out_stall is high.
// rst (synchronous) clears the valid bits; payload registers are not reset.
// Stage split: 1 clamp + sector + 425*offset, 2 ramp /100 + base color,
// 3 (255-c)*(100-S), 4 lift /100 + add, 5 c*V, 6 /100 into output register.
module hsv_percent_to_rgb import hsvp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HueW-1:0]  hue,
  input  logic [PctW-1:0]  saturation,
  input  logic [PctW-1:0]  brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  // sector -> lift
  logic            sec_valid, sec_stall;
  rgb_t            sec_base;
  logic [PctW-1:0] sec_inv, sec_val;
  // lift -> scale
  logic            lift_valid, lift_stall;
  rgb_t            lift_pix;
  logic [PctW-1:0] lift_val;
  // final pixel
  rgb_t            pix;

  hsvp_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (sec_valid),
    .out_stall  (sec_stall),
    .base       (sec_base),
    .inv_sat    (sec_inv),
    .val        (sec_val)
  );

  hsvp_lift u_lift (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_stall  (sec_stall),
    .base      (sec_base),
    .inv_sat   (sec_inv),
    .val       (sec_val),
    .out_valid (lift_valid),
    .out_stall (lift_stall),
    .lifted    (lift_pix),
    .val_out   (lift_val)
  );

  hsvp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lift_valid),
    .in_stall  (lift_stall),
    .lifted    (lift_pix),
    .val       (lift_val),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pix       (pix)
  );

  assign red   = pix.r;
  assign green = pix.g;
  assign blue  = pix.b;

endmodule

[hw/rtl/hsvp_checker.sv]
// Port-level checker for the HSV-percent to RGB converter, with its bind.
module hsvp_checker import hsvp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [ChanW-1:0] red,
  input logic [ChanW-1:0] green,
  input logic [ChanW-1:0] blue
);

  // stalled result holds its valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled output transaction changed");

  // input only backs up when the output is full and stalled
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output can drain");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // an accepted input reaches a valid output when the output never stalls
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(in_valid && !in_stall, 5) && !out_stall && $past(!out_stall, 1) &&
    $past(!out_stall, 2) && $past(!out_stall, 3) && $past(!out_stall, 4) &&
    !$past(rst, 5) && !$past(rst, 4) && !$past(rst, 3) && !$past(rst, 2) &&
    !$past(rst, 1) |=> out_valid)
    else $error("result missing six cycles after input transaction");

endmodule

bind hsv_percent_to_rgb hsvp_checker u_hsvp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .red       (red),
  .green     (green),
  .blue      (blue)
);
